// ----- hdl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the rc4 stream cipher: widths, register
// indexes, payload items and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

	// widths and sizes
	localparam int BYTE_W            = 8;
	localparam int PERM_DEPTH        = 256;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;
	localparam int KEY_LEN_W         = 6;
	localparam int KEY_BYTES_PER_REG = CFG_DATA_W / BYTE_W;
	localparam int MAX_KEY_BYTES_DEF = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd4;

	// input item
	typedef struct packed {
		logic [BYTE_W-1:0] data_in;
		logic              first_of_message;
		logic              last_of_message;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic              last_out;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take;        // latch the accepted item
		logic read_i;      // read S[i+1]
		logic swap_j;      // read old S[j'], write S[j'] = S[i]
		logic swap_i;      // write S[i] = old S[j'], read keystream entry
		logic load_out;    // load the result register
		logic init_wr;     // identity fill, one entry a cycle
		logic ks_read_n;   // key schedule: read S[n], retire previous swap
		logic ks_swap_j;   // key schedule: read old S[j], write S[j] = S[n]
		logic ks_write_n;  // key schedule: retire last swap, clear indices
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic restart;     // accepted item must rebuild the permutation
		logic n_last;      // sweep counter at its last entry
	} status_t;

	// controller states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_INIT = 8'b0000_0010,
		ST_KA   = 8'b0000_0100,
		ST_KB   = 8'b0000_1000,
		ST_KW   = 8'b0001_0000,
		ST_PR   = 8'b0010_0000,
		ST_P2   = 8'b0100_0000,
		ST_P3   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/rc4_stream_if.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer of the cipher: permutation rebuild (identity fill and key
// schedule), per-byte swap/keystream steps and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire rc4_pkg::status_t status,
	output rc4_pkg::cmd_t         cmd
);

	rc4_pkg::state_t state_q, state_nx;
	logic            pend_q;
	logic            out_valid_q;
	logic            out_free;
	logic            idle;
	logic            take;
	logic            load;

	// handshake decisions
	assign idle     = (state_q == rc4_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = idle && (!pend_q || out_free);
	assign take     = in_valid && in_ready;
	assign load     = idle && pend_q && out_free;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				cmd.load_out = load;
				if (take) begin
					cmd.take   = 1'b1;
					cmd.read_i = 1'b1;
					state_nx   = status.restart ? rc4_pkg::ST_INIT : rc4_pkg::ST_P2;
				end
			end
			rc4_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (status.n_last) state_nx = rc4_pkg::ST_KA;
			end
			rc4_pkg::ST_KA: begin
				cmd.ks_read_n = 1'b1;
				state_nx      = rc4_pkg::ST_KB;
			end
			rc4_pkg::ST_KB: begin
				cmd.ks_swap_j = 1'b1;
				state_nx      = status.n_last ? rc4_pkg::ST_KW : rc4_pkg::ST_KA;
			end
			rc4_pkg::ST_KW: begin
				cmd.ks_write_n = 1'b1;
				state_nx       = rc4_pkg::ST_PR;
			end
			rc4_pkg::ST_PR: begin
				cmd.read_i = 1'b1;
				state_nx   = rc4_pkg::ST_P2;
			end
			rc4_pkg::ST_P2: begin
				cmd.swap_j = 1'b1;
				state_nx   = rc4_pkg::ST_P3;
			end
			rc4_pkg::ST_P3: begin
				cmd.swap_i = 1'b1;
				state_nx   = rc4_pkg::ST_IDLE;
			end
			default: state_nx = rc4_pkg::ST_IDLE;
		endcase
	end

	// state, pending keystream and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == rc4_pkg::ST_P3) pend_q <= 1'b1;
			else if (load) pend_q <= 1'b0;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rc4_dp.sv -----
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath of the cipher: key registers, 256x8 permutation memory with one
// write and one registered read port, indices, sweep counter and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire rc4_pkg::in_item_t                 item_in,
	output rc4_pkg::out_item_t                     item_out,
	input  wire rc4_pkg::cmd_t                     cmd,
	output rc4_pkg::status_t                       status
);

	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int BW     = rc4_pkg::BYTE_W;
	localparam int LW     = rc4_pkg::KEY_LEN_W;

	logic [BW-1:0]     key_q [MAX_KEY_BYTES];
	logic [LW-1:0]     klen_q;
	logic [LW-1:0]     eff_len;
	logic [KIDX_W-1:0] kidx_q;
	logic              kidx_wrap;

	logic [BW-1:0] perm_mem [rc4_pkg::PERM_DEPTH];
	logic [BW-1:0] rd_q;
	logic          mem_we, mem_re;
	logic [BW-1:0] mem_wa, mem_wd, mem_ra;

	logic          open_q;
	logic [BW-1:0] i_q, j_q, ip_q, n_q;
	logic [BW-1:0] si_q, sj_q;
	logic          hit_q;
	logic [BW-1:0] data_q;
	logic          last_q;
	logic [BW-1:0] out_data_q;
	logic          out_last_q;

	logic [BW-1:0] i_next, jp, jn, t_addr, n_prev, ks;

	// key bytes, each from its own register and byte lane
	for (genvar k = 0; k < MAX_KEY_BYTES; k++) begin : g_key
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				key_q[k] <= '0;
			end else if (cfg_we &&
					cfg_index == rc4_pkg::CFG_IDX_W'(k / rc4_pkg::KEY_BYTES_PER_REG)) begin
				key_q[k] <= cfg_wdata[(k % rc4_pkg::KEY_BYTES_PER_REG)*BW +: BW];
			end
		end
	end

	// key length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= LW'(1);
		end else if (cfg_we && cfg_index == rc4_pkg::REG_KEY_LEN) begin
			klen_q <= cfg_wdata[LW-1:0];
		end
	end

	// key length in use: zero acts as one, saturate at the key storage
	always_comb begin
		if (klen_q == '0) eff_len = LW'(1);
		else if (klen_q > LW'(MAX_KEY_BYTES)) eff_len = LW'(MAX_KEY_BYTES);
		else eff_len = klen_q;
	end
	assign kidx_wrap = (LW'(kidx_q) == eff_len - LW'(1));

	// address arithmetic
	assign i_next = i_q + 8'd1;
	assign jp     = j_q + rd_q;
	assign jn     = j_q + rd_q + key_q[kidx_q];
	assign t_addr = si_q + rd_q;
	assign n_prev = n_q - 8'd1;
	assign ks     = hit_q ? sj_q : rd_q;

	// memory port selection
	always_comb begin
		mem_re = 1'b0;
		mem_ra = i_next;
		mem_we = 1'b0;
		mem_wa = n_prev;
		mem_wd = rd_q;
		if (cmd.read_i) begin
			mem_re = 1'b1;
			mem_ra = i_next;
		end
		if (cmd.swap_j) begin
			mem_re = 1'b1;
			mem_ra = jp;
			mem_we = 1'b1;
			mem_wa = jp;
		end
		if (cmd.swap_i) begin
			mem_re = 1'b1;
			mem_ra = t_addr;
			mem_we = 1'b1;
			mem_wa = ip_q;
		end
		if (cmd.init_wr) begin
			mem_we = 1'b1;
			mem_wa = n_q;
			mem_wd = n_q;
		end
		if (cmd.ks_read_n) begin
			mem_re = 1'b1;
			mem_ra = n_q;
			mem_we = (n_q != '0);
			mem_wa = n_prev;
		end
		if (cmd.ks_swap_j) begin
			mem_re = 1'b1;
			mem_ra = jn;
			mem_we = 1'b1;
			mem_wa = jn;
		end
		if (cmd.ks_write_n) begin
			mem_we = 1'b1;
			mem_wa = n_prev;
		end
	end

	// permutation memory, read returns the old entry on a same-address write
	always_ff @(posedge clk) begin
		if (mem_we) perm_mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= perm_mem[mem_ra];
	end

	// indices, sweep counter and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			n_q    <= '0;
			kidx_q <= '0;
		end else begin
			if (cmd.take) begin
				open_q <= !item_in.last_of_message;
				n_q    <= '0;
				kidx_q <= '0;
			end
			if (cmd.swap_j) j_q <= jp;
			if (cmd.swap_i) i_q <= ip_q;
			// identity fill, key schedule starts from j = 0
			if (cmd.init_wr) begin
				n_q <= n_q + 8'd1;
				j_q <= '0;
			end
			if (cmd.ks_swap_j) begin
				j_q    <= jn;
				n_q    <= n_q + 8'd1;
				kidx_q <= kidx_wrap ? '0 : kidx_q + KIDX_W'(1);
			end
			if (cmd.ks_write_n) begin
				i_q <= '0;
				j_q <= '0;
			end
		end
	end

	// payload and swap operands
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			data_q <= item_in.data_in;
			last_q <= item_in.last_of_message;
		end
		if (cmd.read_i) ip_q <= i_next;
		if (cmd.swap_j) si_q <= rd_q;
		if (cmd.swap_i) begin
			sj_q  <= rd_q;
			hit_q <= (t_addr == ip_q);
		end
		if (cmd.ks_swap_j) si_q <= rd_q;
		if (cmd.load_out) begin
			out_data_q <= data_q ^ ks;
			out_last_q <= last_q;
		end
	end

	assign item_out.data_out = out_data_q;
	assign item_out.last_out = out_last_q;

	assign status.restart = item_in.first_of_message || !open_q;
	assign status.n_last  = (n_q == '1);

endmodule

`default_nettype wire

// ----- hdl/rc4_stream_cipher.sv -----
// A result in a message goes through states P2 and P3 and is loaded in idle once the
// output is free. A new item is taken only in idle, after the last one's swap steps,
// which the single-write-port RAM serialises. A restart (first byte, or a byte with
// no message open) adds 256 identity writes, a read and swap step (KA, KB) per entry
// and the states KW and PR. Reset clears control, indices, key registers and sets
// key length to 1; the permutation RAM is not cleared and is rebuilt before any read.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte stream cipher top level: configuration port, channel handshakes,
// controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rc4_stream_if.sink                          feed,
	rc4_stream_if.source                        result
);

	rc4_pkg::cmd_t      cmd;
	rc4_pkg::status_t   status;
	rc4_pkg::in_item_t  item_in;
	rc4_pkg::out_item_t item_out;
	logic               in_ready;
	logic               out_valid;

	// channel payloads
	assign item_in        = feed.payload;
	assign feed.ready     = in_ready;
	assign result.valid   = out_valid;
	assign result.payload = item_out;

	// sequencer
	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feed.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	rc4_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item_in   (item_in),
		.item_out  (item_out),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

// ----- sim/tb_rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// tb_rc4_stream_cipher
// Self-checking bench for the rc4 stream cipher: drives bytes through the
// valid/ready feed, rebuilds the permutation and keystream in a local
// predictor, and compares every result byte and last flag in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rc4_stream_cipher;

	localparam int unsigned CYCLE_LIMIT  = 5_000_000;
	localparam int unsigned IDLE_SETTLE  = 8;
	localparam int unsigned END_SETTLE   = 16;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned RANDOM_ITEMS = 1280;

	localparam int BW = rc4_pkg::BYTE_W;
	localparam int IW = rc4_pkg::CFG_IDX_W;
	localparam int DW = rc4_pkg::CFG_DATA_W;
	localparam int LW = rc4_pkg::KEY_LEN_W;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IW-1:0] cfg_index;
	logic [DW-1:0] cfg_wdata;

	rc4_stream_if #(.item_t(rc4_pkg::in_item_t))  feed_if ();
	rc4_stream_if #(.item_t(rc4_pkg::out_item_t)) result_if ();

	rc4_stream_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.feed      (feed_if),
		.result    (result_if)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: key registers, permutation, indices, message flag
	logic [DW-1:0] key_words [4];
	logic [LW-1:0] key_len_reg;
	logic [BW-1:0] sbox [rc4_pkg::PERM_DEPTH];
	logic [BW-1:0] idx_i;
	logic [BW-1:0] idx_j;
	bit            msg_open;

	rc4_pkg::out_item_t expected_bytes [$];
	int unsigned        mismatch_count;
	int unsigned        cycle_count;
	int unsigned        src_gap_max;
	int unsigned        snk_gap_max;
	int unsigned        hold_request;

	// key byte n of the key registers
	function automatic logic [BW-1:0] key_byte_at(int n);
		return key_words[n / rc4_pkg::KEY_BYTES_PER_REG]
			[(n % rc4_pkg::KEY_BYTES_PER_REG) * BW +: BW];
	endfunction

	// identity fill, key schedule, indices cleared
	function automatic void schedule_key();
		int            len;
		logic [BW-1:0] j;
		logic [BW-1:0] t;
		len = int'(key_len_reg);
		if (len == 0)
			len = 1;
		if (len > rc4_pkg::MAX_KEY_BYTES_DEF)
			len = rc4_pkg::MAX_KEY_BYTES_DEF;
		for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
			sbox[n] = BW'(n);
		j = '0;
		for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
			j = j + sbox[n] + key_byte_at(n % len);
			t = sbox[n];
			sbox[n] = sbox[j];
			sbox[j] = t;
		end
		idx_i = '0;
		idx_j = '0;
	endfunction

	// one byte through the cipher
	function automatic rc4_pkg::out_item_t encipher_byte(rc4_pkg::in_item_t item);
		rc4_pkg::out_item_t r;
		logic [BW-1:0]      t;
		logic [BW-1:0]      ks_idx;
		if (item.first_of_message || !msg_open)
			schedule_key();
		idx_i = idx_i + 1'b1;
		idx_j = idx_j + sbox[idx_i];
		t = sbox[idx_i];
		sbox[idx_i] = sbox[idx_j];
		sbox[idx_j] = t;
		ks_idx = sbox[idx_i] + sbox[idx_j];
		r.data_out = item.data_in ^ sbox[ks_idx];
		r.last_out = item.last_of_message;
		msg_open = !item.last_of_message;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on %s at cycle %0d: got %0h, expected %0h",
			what, cycle_count, got, want);
		mismatch_count++;
	endtask

	// register write, mirrored into the predictor
	task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx <= rc4_pkg::REG_KEY_24_31)
			key_words[idx] = value;
		else if (idx == rc4_pkg::REG_KEY_LEN)
			key_len_reg = value[LW-1:0];
	endtask

	// offer one item after a random gap, predict on acceptance
	task automatic send_byte(logic [BW-1:0] data, bit first, bit last);
		int unsigned       gap;
		rc4_pkg::in_item_t item;
		gap = $urandom_range(0, src_gap_max);
		item.data_in          = data;
		item.first_of_message = first;
		item.last_of_message  = last;
		@(negedge clk);
		if (gap > 0) begin
			feed_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		feed_if.valid   = 1'b1;
		feed_if.payload = item;
		do @(posedge clk); while (!feed_if.ready);
		expected_bytes.push_back(encipher_byte(item));
	endtask

	task automatic stop_feed();
		@(negedge clk);
		feed_if.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		stop_feed();
		wait_drained();
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold on request
	initial begin
		int unsigned gap;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				result_if.ready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			gap = $urandom_range(0, snk_gap_max);
			if (gap > 0) begin
				result_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_if.ready = 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		rc4_pkg::out_item_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected item", 32'(result_if.payload), 32'd0);
			end else begin
				want = expected_bytes.pop_front();
				if (result_if.payload.data_out !== want.data_out)
					report_mismatch("data_out", 32'(result_if.payload.data_out),
						32'(want.data_out));
				if (result_if.payload.last_out !== want.last_out)
					report_mismatch("last_out", 32'(result_if.payload.last_out),
						32'(want.last_out));
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// reset key and length: bytes with and without an open message
	task automatic test_reset_state();
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'hA5, 1'b1, 1'b1);
	endtask

	// three-byte key over a short text
	task automatic test_known_key();
		byte unsigned text [9];
		text = '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};
		wait_idle();
		write_reg(rc4_pkg::REG_KEY_0_7, 64'h0000_0000_0079_654B);
		write_reg(rc4_pkg::REG_KEY_LEN, 64'd3);
		for (int k = 0; k < 9; k++)
			send_byte(text[k], k == 0, k == 8);
	endtask

	// full key, zero length, saturated length, unmapped indexes
	task automatic test_key_length_limits();
		wait_idle();
		write_reg(rc4_pkg::REG_KEY_0_7, '0);
		write_reg(rc4_pkg::REG_KEY_8_15, '1);
		write_reg(rc4_pkg::REG_KEY_16_23, 64'hAAAA_AAAA_AAAA_AAAA);
		write_reg(rc4_pkg::REG_KEY_24_31, 64'h5555_5555_5555_5555);
		write_reg(rc4_pkg::REG_KEY_LEN, 64'd32);
		send_byte(8'h01, 1'b1, 1'b0);
		send_byte(8'h80, 1'b0, 1'b1);
		wait_idle();
		write_reg(rc4_pkg::REG_KEY_LEN, 64'd0);
		send_byte(8'h7F, 1'b1, 1'b1);
		wait_idle();
		write_reg(rc4_pkg::REG_KEY_LEN, 64'd63);
		send_byte(8'hFE, 1'b1, 1'b1);
		wait_idle();
		write_reg(rc4_pkg::REG_KEY_LEN, 64'd33);
		send_byte(8'h55, 1'b1, 1'b1);
		wait_idle();
		for (int k = 1; k <= 3; k++)
			write_reg(rc4_pkg::REG_KEY_LEN + IW'(k), '1);
		send_byte(8'hAA, 1'b1, 1'b1);
	endtask

	// key write inside an open message, then restarts
	task automatic test_rekey_open_message();
		wait_idle();
		send_byte(8'h3C, 1'b1, 1'b0);
		wait_idle();
		write_reg(rc4_pkg::REG_KEY_0_7, 64'h0123_4567_89AB_CDEF);
		write_reg(rc4_pkg::REG_KEY_LEN, 64'd5);
		send_byte(8'hC3, 1'b0, 1'b0);
		send_byte(8'h0F, 1'b1, 1'b1);
		send_byte(8'hF0, 1'b0, 1'b1);
	endtask

	// long output hold while the feed keeps offering, then a sender pause
	task automatic test_output_stall();
		wait_idle();
		src_gap_max  = 0;
		snk_gap_max  = 0;
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 24; k++) begin
			if (k == 16) begin
				stop_feed();
				wait_drained();
			end
			send_byte(BW'($urandom), k == 0, k == 23);
		end
	endtask

	// new key and length, random subset of registers
	task automatic rekey_random();
		logic [DW-1:0] len;
		wait_idle();
		for (int r = 0; r <= rc4_pkg::REG_KEY_24_31; r++)
			if ($urandom_range(0, 1))
				write_reg(IW'(r), {$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: len = '0;
			1: len = DW'(1);
			2: len = DW'(rc4_pkg::MAX_KEY_BYTES_DEF);
			3: len = DW'(63);
			4: len = DW'($urandom_range(33, 62));
			default: len = DW'($urandom_range(1, rc4_pkg::MAX_KEY_BYTES_DEF));
		endcase
		len[DW-1:LW] = (DW-LW)'({$urandom, $urandom});
		write_reg(rc4_pkg::REG_KEY_LEN, len);
		if ($urandom_range(0, 3) == 0)
			write_reg(rc4_pkg::REG_KEY_LEN + IW'($urandom_range(1, 3)),
				{$urandom, $urandom});
	endtask

	// mostly well-formed messages, some broken or noisy ones
	task automatic test_random_messages(int unsigned n_items);
		int unsigned sent;
		int unsigned msg_len;
		int unsigned shape;
		bit          first_flag;
		bit          last_flag;
		sent = 0;
		while (sent < n_items) begin
			rekey_random();
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			repeat ($urandom_range(3, 8)) begin
				shape   = $urandom_range(0, 9);
				msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
					: $urandom_range(1, 24);
				for (int k = 0; k < msg_len; k++) begin
					case (shape)
						0: begin
							first_flag = ($urandom_range(0, 5) == 0);
							last_flag  = ($urandom_range(0, 5) == 0);
						end
						1: begin
							first_flag = 1'b0;
							last_flag  = (k == msg_len - 1);
						end
						2: begin
							first_flag = (k == 0);
							last_flag  = 1'b0;
						end
						default: begin
							first_flag = (k == 0);
							last_flag  = (k == msg_len - 1);
						end
					endcase
					if ($urandom_range(0, 63) == 0) begin
						stop_feed();
						wait_drained();
					end
					send_byte(BW'($urandom), first_flag, last_flag);
					sent++;
				end
			end
		end
	endtask

	// reset, tests in turn, final verdict
	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		feed_if.valid   = 1'b0;
		feed_if.payload = '0;
		mismatch_count  = 0;
		hold_request    = 0;
		src_gap_max     = 15;
		snk_gap_max     = 15;
		for (int r = 0; r < 4; r++)
			key_words[r] = '0;
		key_len_reg = LW'(1);
		for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
			sbox[n] = '0;
		idx_i    = '0;
		idx_j    = '0;
		msg_open = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_known_key();
		test_key_length_limits();
		test_rekey_open_message();
		test_output_stall();
		test_random_messages(RANDOM_ITEMS);

		wait_idle();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
